// File: design/lrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_pkg: shared types and constants of the 5x5 local range filter
// Word layouts of both channels, configuration register indexes and the
// column summary that the horizontal cells pass along.
// ----------------------------------------------------------------------------
package lrf_pkg;

	localparam int PIX_W     = 8;
	localparam int LS_LANES  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 11;
	localparam int WIN       = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam int CFG_WIDTH_RESET  = 1024;
	localparam int CFG_HEIGHT_RESET = 1024;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel_value;
	} lrf_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] range_value;
		logic             row_last;
		logic             frame_last;
	} lrf_out_t;

	typedef struct packed {
		logic [PIX_W-1:0] max_v;
		logic [PIX_W-1:0] min_v;
	} lrf_col_t;

	typedef struct packed {
		logic           em;
		logic [WIN-1:0] hm;
		logic           rl;
		logic           fl;
	} lrf_emit_t;

	typedef logic [LS_LANES:0][PIX_W-1:0] lrf_taps_t;

endpackage
`default_nettype wire

// File: design/lrf_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_line_store: four line stores in one memory word per column
// Each column entry holds the four previous rows; a step reads the entry,
// shifts the new pixel in and writes it back from the s2 stage.
// ----------------------------------------------------------------------------
module lrf_line_store #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          step_s1,
	input  wire logic [AW-1:0]                 addr_s1,
	input  wire logic [lrf_pkg::PIX_W-1:0]     pix_s1,
	output logic                               step_s2,
	output lrf_pkg::lrf_taps_t                 taps
);

	localparam int WW = lrf_pkg::LS_LANES * lrf_pkg::PIX_W;

	logic [WW-1:0]             mem [DEPTH];
	logic [WW-1:0]             rd_s2;
	logic [WW-1:0]             last_q;
	logic [WW-1:0]             old_w;
	logic [WW-1:0]             wr_w;
	logic [AW-1:0]             addr_s2;
	logic [lrf_pkg::PIX_W-1:0] pix_s2;
	logic                      byp_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s2 <= mem[addr_s1];
			addr_s2 <= addr_s1;
			pix_s2 <= pix_s1;
			if (step_s2) begin
				mem[addr_s2] <= wr_w;
				last_q <= wr_w;
			end
		end
	end

	// A step that reads the column the step ahead is writing takes the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s2 <= 1'b0;
			byp_s2 <= 1'b0;
		end else if (adv) begin
			step_s2 <= step_s1;
			byp_s2 <= step_s2 && (addr_s2 == addr_s1);
		end
	end

	assign old_w = byp_s2 ? last_q : rd_s2;
	assign wr_w = {old_w[WW-lrf_pkg::PIX_W-1:0], pix_s2};

	always_comb begin
		taps[0] = pix_s2;
		for (int k = 1; k <= lrf_pkg::LS_LANES; k++) begin
			taps[k] = old_w[k*lrf_pkg::PIX_W-1 -: lrf_pkg::PIX_W];
		end
	end

endmodule
`default_nettype wire

// File: design/lrf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_cell: one column of the horizontal window
// Holds a column maximum and minimum, hands it to the next cell on a step
// and offers it to the range reduction when its column lies in the frame.
// ----------------------------------------------------------------------------
module lrf_cell (
	input  wire logic              clk,
	input  wire logic              shift,
	input  wire logic              use_en,
	input  wire lrf_pkg::lrf_col_t d,
	output lrf_pkg::lrf_col_t      q,
	output lrf_pkg::lrf_col_t      masked
);

	always_ff @(posedge clk) begin
		if (shift) begin
			q <= d;
		end
	end

	always_comb begin
		if (use_en) begin
			masked = q;
		end else begin
			masked.max_v = '0;
			masked.min_v = '1;
		end
	end

endmodule
`default_nettype wire

// File: design/local_range_filter_5x5_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// local_range_filter_5x5_top: streaming 5x5 maximum minus minimum
// Raster pixels in, one range word out per neighbourhood, edges replicated.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       word
//  item      in         item_valid / item_stall         lrf_in_t (kind, pixel_value)
//  result    out        result_valid / result_stall     lrf_out_t (range, row/frame last)
//  cfg       in         cfg_we, cfg_index, cfg_data     width (0), height (1)
//
// One word is taken every cycle while the input is not stalled; its result
// passes the line store read, the vertical and horizontal reductions and
// leaves the output register. When a frame of fewer than 2*width+2 pixels
// ends, internal fill steps hold the input stalled until 2*width+2 steps are done.
// A stalled result freezes the whole pipeline and stalls the input.
// Reset clears control only; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module local_range_filter_5x5_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire lrf_pkg::lrf_in_t                item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output lrf_pkg::lrf_out_t                    result,
	input  wire logic                            cfg_we,
	input  wire logic [lrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lrf_pkg::CFG_W-1:0]       cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = $clog2(MAX_HEIGHT + 8);
	localparam int TW = $clog2(2 * MAX_WIDTH + 3);
	localparam int RST_W = (lrf_pkg::CFG_WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : lrf_pkg::CFG_WIDTH_RESET;
	localparam int RST_H = (lrf_pkg::CFG_HEIGHT_RESET > MAX_HEIGHT) ?
		MAX_HEIGHT : lrf_pkg::CFG_HEIGHT_RESET;
	localparam int WIN = lrf_pkg::WIN;
	localparam int PW = lrf_pkg::PIX_W;

	function automatic int eff_dim(input logic [lrf_pkg::CFG_W-1:0] v, input int maxv);
		int x;
		x = int'(v);
		if (x < 1) begin
			return 1;
		end
		if (x > maxv) begin
			return maxv;
		end
		return x;
	endfunction

	// Geometry, derived once on a register write.
	logic [CW-1:0] wm1_q;
	logic [RW-1:0] hm1_q;
	logic [TW-1:0] thr_q;
	int            w_eff;
	int            h_eff;

	// Frame position state.
	logic [CW-1:0] vc_q;
	logic [RW-1:0] vr_q;
	logic [TW-1:0] cnt_q;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;
	logic          fr_q;

	logic adv, thr_hit, acc, fill, pstep, dstep, step, emit, rl0, fl0, cfg_hit;
	logic [WIN-1:0] vm0;
	logic [WIN-1:0] hm0;

	assign w_eff = eff_dim(cfg_data, MAX_WIDTH);
	assign h_eff = eff_dim(cfg_data, MAX_HEIGHT);
	assign cfg_hit = cfg_we && ((cfg_index == lrf_pkg::CFG_WIDTH) ||
		(cfg_index == lrf_pkg::CFG_HEIGHT));

	assign adv = !result_valid || !result_stall;
	assign thr_hit = (cnt_q == thr_q);
	// Small frames need extra silent steps before the first drain word.
	assign item_stall = !adv || (fr_q && !thr_hit);
	assign fill = adv && fr_q && !thr_hit;
	assign acc = item_valid && !item_stall;
	assign pstep = acc && (item.kind == lrf_pkg::KIND_PIXEL) && !fr_q;
	assign dstep = acc && (item.kind == lrf_pkg::KIND_DRAIN) && fr_q;
	assign step = fill || pstep || dstep;
	assign emit = (pstep && thr_hit) || dstep;
	assign rl0 = (ocol_q == wm1_q);
	assign fl0 = rl0 && (orow_q == hm1_q);

	// Row tap k is row vr-k; it counts only when that row lies in the frame.
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			vm0[k] = (vr_q >= RW'(k)) && (vr_q <= hm1_q + RW'(k));
		end
	end

	// Cells hold columns ocol+2 down to ocol-2, newest first.
	assign hm0[0] = ({2'b00, ocol_q} + (CW+2)'(2)) <= {2'b00, wm1_q};
	assign hm0[1] = ({2'b00, ocol_q} + (CW+2)'(1)) <= {2'b00, wm1_q};
	assign hm0[2] = 1'b1;
	assign hm0[3] = (ocol_q != '0);
	assign hm0[4] = (ocol_q > CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= CW'(RST_W - 1);
			hm1_q <= RW'(RST_H - 1);
			thr_q <= TW'(2 * RST_W + 2);
			vc_q <= '0;
			vr_q <= '0;
			cnt_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			fr_q <= 1'b0;
		end else if (cfg_hit) begin
			if (cfg_index == lrf_pkg::CFG_WIDTH) begin
				wm1_q <= CW'(w_eff - 1);
				thr_q <= TW'(2 * w_eff + 2);
			end else begin
				hm1_q <= RW'(h_eff - 1);
			end
			vc_q <= '0;
			vr_q <= '0;
			cnt_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			fr_q <= 1'b0;
		end else if (step) begin
			if (vc_q == wm1_q) begin
				vc_q <= '0;
				vr_q <= vr_q + RW'(1);
			end else begin
				vc_q <= vc_q + CW'(1);
			end
			if (!thr_hit) begin
				cnt_q <= cnt_q + TW'(1);
			end
			if (pstep && (vc_q == wm1_q) && (vr_q == hm1_q)) begin
				fr_q <= 1'b1;
			end
			if (emit) begin
				if (fl0) begin
					vc_q <= '0;
					vr_q <= '0;
					cnt_q <= '0;
					ocol_q <= '0;
					orow_q <= '0;
					fr_q <= 1'b0;
				end else if (rl0) begin
					ocol_q <= '0;
					orow_q <= orow_q + RW'(1);
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
		end
	end

	// Pipeline.
	logic                step_s1, step_s3;
	logic [CW-1:0]       c_s1;
	logic [PW-1:0]       pix_s1;
	logic [WIN-1:0]      vm_s1, vm_s2;
	lrf_pkg::lrf_emit_t  em_s1, em_s2, em_s3, em_s4;
	logic                ls_step_s2;
	lrf_pkg::lrf_taps_t  taps;
	lrf_pkg::lrf_col_t   col_w, col_s3;
	lrf_pkg::lrf_out_t   result_q;
	logic                result_valid_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= vc_q;
			pix_s1 <= item.pixel_value;
			vm_s1 <= vm0;
			vm_s2 <= vm_s1;
			col_s3 <= col_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
			step_s3 <= 1'b0;
			em_s1 <= '0;
			em_s2 <= '0;
			em_s3 <= '0;
			em_s4 <= '0;
		end else if (adv) begin
			step_s1 <= step;
			step_s3 <= ls_step_s2;
			em_s1 <= '{em: emit, hm: hm0, rl: rl0, fl: fl0};
			em_s2 <= em_s1;
			em_s3 <= em_s2;
			em_s4 <= em_s3;
		end
	end

	lrf_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.step_s1 (step_s1),
		.addr_s1 (c_s1),
		.pix_s1  (pix_s1),
		.step_s2 (ls_step_s2),
		.taps    (taps)
	);

	always_comb begin
		col_w.max_v = '0;
		col_w.min_v = '1;
		for (int k = 0; k < WIN; k++) begin
			if (vm_s2[k] && (taps[k] > col_w.max_v)) begin
				col_w.max_v = taps[k];
			end
			if (vm_s2[k] && (taps[k] < col_w.min_v)) begin
				col_w.min_v = taps[k];
			end
		end
	end

	lrf_pkg::lrf_col_t cell_q [WIN];
	lrf_pkg::lrf_col_t cell_m [WIN];

	for (genvar j = 0; j < WIN; j++) begin : g_cell
		lrf_cell u_cell (
			.clk    (clk),
			.shift  (adv && step_s3),
			.use_en (em_s4.hm[j]),
			.d      ((j == 0) ? col_s3 : cell_q[(j == 0) ? 0 : j - 1]),
			.q      (cell_q[j]),
			.masked (cell_m[j])
		);
	end

	logic [PW-1:0] hmax, hmin;

	always_comb begin
		hmax = '0;
		hmin = '1;
		for (int j = 0; j < WIN; j++) begin
			if (cell_m[j].max_v > hmax) begin
				hmax = cell_m[j].max_v;
			end
			if (cell_m[j].min_v < hmin) begin
				hmin = cell_m[j].min_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.range_value <= hmax - hmin;
			result_q.row_last <= em_s4.rl;
			result_q.frame_last <= em_s4.fl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= em_s4.em;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
`default_nettype wire

// File: design/lrf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_checker: port-level checks of the local range filter
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lrf_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire lrf_pkg::lrf_out_t result
);

	// A full, stalled output register must hold the input back.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> item_stall)
		else $error("input taken while the result word is stalled");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.frame_last || result.row_last))
		else $error("frame end without row end");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(result))
		else $error("stalled result word changed");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("stalled result word withdrawn");

endmodule

bind local_range_filter_5x5_top lrf_checker u_lrf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
